// ===== design/gpi_lep_pkg.sv =====
// Package for the GPI line event parser: sizing constants, character codes
// and the parse phase type. Used by gpi_line_event_parser_core.
`default_nettype none

package gpi_lep_pkg;

    localparam int LINE_LIMIT = 256;
    localparam int PIN_COUNT  = 5;

    localparam int LEN_W  = $clog2(LINE_LIMIT);
    localparam int PCNT_W = $clog2(PIN_COUNT + 1);
    localparam int PORT_W = 16;
    localparam int OWN_W  = 3;

    localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};
    localparam logic [OWN_W-1:0]  OWN_PORT_RESET = OWN_W'(1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_L_UP  = 8'h4C;
    localparam logic [7:0] CH_L_LO  = 8'h6C;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_G,
        PH_GP,
        PH_GPI,
        PH_PRESIGN,
        PH_NEEDDIGIT,
        PH_DIGITS,
        PH_PRESPACE,
        PH_PINS,
        PH_TAIL,
        PH_FAIL,
        PH_DONE_OK
    } t_phase;

endpackage

`default_nettype wire

// ===== design/gpi_line_event_parser_core.sv =====
// A result is registered from the transaction carrying the CR or LF that ends
//   its line. Throughput: one byte per cycle while o_stall is low.
// A two-entry output buffer (result register plus skid) lets bytes flow while a
//   result waits; o_stall rises only while the skid entry is occupied.
// Reset (synchronous, i_rst_n low): line state cleared, own port set to 1,
//   output buffer emptied.
// GPI line parser core; depends on gpi_lep_pkg.
`default_nettype none

module gpi_line_event_parser_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gpi_lep_pkg::OWN_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_new_session,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_play_pause,
    output logic                           o_preview_toggle
);
    import gpi_lep_pkg::*;

    logic [OWN_W-1:0]  r_own_port;
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_line_len, n_line_len;
    logic [PORT_W-1:0] r_port, n_port;
    logic [PCNT_W-1:0] r_pins_seen, n_pins_seen;
    logic [1:0]        r_pin_flags, n_pin_flags;

    logic       r_out_valid, r_skid_valid;
    logic [1:0] r_out_data, r_skid_data;

    logic              accept, is_eol, is_ws, is_digit;
    logic [3:0]        digit;
    logic [PORT_W+3:0] port_mac;
    logic [PORT_W-1:0] port_acc;
    logic              pin_ok;
    logic [PCNT_W-1:0] pin_cnt_inc;
    logic [1:0]        pin_flags_upd;
    t_phase            pin_phase;
    logic              line_ok, push, pop;
    logic [1:0]        result;

    assign accept   = i_valid && !o_stall;
    assign is_eol   = (i_rx_byte == CH_LF) || (i_rx_byte == CH_CR);
    assign is_ws    = (i_rx_byte == CH_SPACE) || (i_rx_byte >= CH_TAB && i_rx_byte <= CH_CR);
    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit    = 4'(i_rx_byte - CH_ZERO);

    assign port_mac = {1'b0, r_port, 3'b000} + {3'b000, r_port, 1'b0} + (PORT_W+4)'(digit);
    assign port_acc = (port_mac > (PORT_W+4)'(PORT_MAX)) ? PORT_MAX : port_mac[PORT_W-1:0];

    assign pin_ok = (i_rx_byte == CH_L_UP) || (i_rx_byte == CH_L_LO)
                 || (i_rx_byte == CH_H_UP) || (i_rx_byte == CH_H_LO);
    assign pin_cnt_inc = r_pins_seen + PCNT_W'(1);

    always_comb begin
        pin_flags_upd = r_pin_flags;
        if (i_rx_byte == CH_L_UP && r_pins_seen < PCNT_W'(2)) begin
            pin_flags_upd[r_pins_seen[0]] = 1'b1;
        end
        if (!pin_ok) begin
            pin_phase = PH_FAIL;
        end else if (pin_cnt_inc >= PCNT_W'(PIN_COUNT)) begin
            pin_phase = PH_TAIL;
        end else begin
            pin_phase = PH_PINS;
        end
    end

    // next state of the line parser
    always_comb begin
        n_phase     = r_phase;
        n_line_len  = r_line_len;
        n_port      = r_port;
        n_pins_seen = r_pins_seen;
        n_pin_flags = r_pin_flags;
        if (accept) begin
            if (i_new_session || (is_eol && r_line_len != '0)) begin
                n_phase     = PH_LEAD;
                n_line_len  = '0;
                n_port      = '0;
                n_pins_seen = '0;
                n_pin_flags = '0;
            end else if (!is_eol && r_line_len < LEN_W'(LINE_LIMIT - 1)) begin
                n_line_len = r_line_len + LEN_W'(1);
                if (r_phase == PH_FAIL || r_phase == PH_DONE_OK) begin
                    n_phase = r_phase;
                end else if (i_rx_byte == CH_NUL) begin
                    n_phase = (r_phase == PH_TAIL) ? PH_DONE_OK : PH_FAIL;
                end else begin
                    unique case (r_phase)
                        PH_LEAD: begin
                            if (!is_ws) n_phase = (i_rx_byte == CH_G) ? PH_G : PH_FAIL;
                        end
                        PH_G: n_phase = (i_rx_byte == CH_P) ? PH_GP : PH_FAIL;
                        PH_GP: n_phase = (i_rx_byte == CH_I) ? PH_GPI : PH_FAIL;
                        PH_GPI: n_phase = (i_rx_byte == CH_SPACE) ? PH_PRESIGN : PH_FAIL;
                        PH_PRESIGN: begin
                            if (is_digit) begin
                                n_port  = PORT_W'(digit);
                                n_phase = PH_DIGITS;
                            end else if (i_rx_byte == CH_PLUS) begin
                                n_phase = PH_NEEDDIGIT;
                            end else if (!is_ws) begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_NEEDDIGIT: begin
                            if (is_digit) begin
                                n_port  = PORT_W'(digit);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit) begin
                                n_port = port_acc;
                            end else if (r_port == '0) begin
                                n_phase = PH_FAIL;
                            end else if (i_rx_byte == CH_SPACE) begin
                                n_phase = PH_PRESPACE;
                            end else begin
                                n_phase = pin_phase;
                                if (pin_ok) begin
                                    n_pins_seen = pin_cnt_inc;
                                    n_pin_flags = pin_flags_upd;
                                end
                            end
                        end
                        PH_PRESPACE, PH_PINS: begin
                            if (!(r_phase == PH_PRESPACE && i_rx_byte == CH_SPACE)) begin
                                n_phase = pin_phase;
                                if (pin_ok) begin
                                    n_pins_seen = pin_cnt_inc;
                                    n_pin_flags = pin_flags_upd;
                                end
                            end
                        end
                        PH_TAIL: begin
                            if (!is_ws) n_phase = PH_FAIL;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        end
    end

    // line-end evaluation
    always_comb begin
        line_ok = (r_phase == PH_TAIL || r_phase == PH_DONE_OK)
               && (r_port == PORT_W'(r_own_port));
        result  = line_ok ? r_pin_flags : 2'b00;
        push    = accept && !i_new_session && is_eol && (r_line_len != '0)
               && (result != 2'b00);
    end

    assign pop     = r_out_valid && !i_stall;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_play_pause     = r_out_data[0];
    assign o_preview_toggle = r_out_data[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_port   <= OWN_PORT_RESET;
            r_phase      <= PH_LEAD;
            r_line_len   <= '0;
            r_port       <= '0;
            r_pins_seen  <= '0;
            r_pin_flags  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_own_port <= i_cfg_data;
            r_phase     <= n_phase;
            r_line_len  <= n_line_len;
            r_port      <= n_port;
            r_pins_seen <= n_pins_seen;
            r_pin_flags <= n_pin_flags;
            priority if (r_skid_valid && pop) begin
                r_skid_valid <= 1'b0;
            end else if (push && r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else if (pop && !push) begin
                r_out_valid <= 1'b0;
            end else if (push) begin
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_valid && pop) begin
            r_out_data <= r_skid_data;
        end else if (push && r_out_valid && !pop) begin
            r_skid_data <= result;
        end else if (push) begin
            r_out_data <= result;
        end else begin
            r_out_data <= r_out_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid entry without result entry");
    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_play_pause || o_preview_toggle)) else $error("empty result shown");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= LEN_W'(LINE_LIMIT - 1)) else $error("line length past limit");
    a_pins_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins_seen <= PCNT_W'(PIN_COUNT)) else $error("pin count past limit");
    a_session_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_new_session) |=> (r_line_len == '0 && r_phase == PH_LEAD))
        else $error("session start did not clear line");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for gpi_line_event_parser_core: drives GPI text lines
// with random idling on both channels and checks every pin event against a
// predictor of the line parser. Depends on gpi_lep_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gpi_lep_pkg::*;

    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic play;
        logic preview;
    } t_pin_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [OWN_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_rx_byte = '0;
    logic               i_new_session = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_play_pause;
    logic               o_preview_toggle;

    gpi_line_event_parser_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_new_session    (i_new_session),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_play_pause     (o_play_pause),
        .o_preview_toggle (o_preview_toggle)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirror
    t_phase             line_phase = PH_LEAD;
    int                 line_len = 0;
    int                 port_acc = 0;
    int                 pin_count = 0;
    logic [1:0]         low_pins = '0;
    logic [OWN_W-1:0]   listen_port = OWN_PORT_RESET;

    t_pin_event         expected_events[$];
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 receiver_holdoff = 0;
    int                 bytes_sent = 0;
    int                 lines_sent = 0;
    int                 events_checked = 0;
    int                 event_mismatches = 0;
    int                 port_writes = 0;
    int unsigned        cycle_count = 0;

    function automatic void clear_line();
        line_phase = PH_LEAD;
        line_len = 0;
        port_acc = 0;
        pin_count = 0;
        low_pins = '0;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void take_pin(input logic [7:0] c);
        if (c == CH_L_UP) begin
            if (pin_count < 2) low_pins[pin_count] = 1'b1;
        end else if (c != CH_L_LO && c != CH_H_UP && c != CH_H_LO) begin
            line_phase = PH_FAIL;
            return;
        end
        pin_count++;
        line_phase = (pin_count >= PIN_COUNT) ? PH_TAIL : PH_PINS;
    endfunction

    function automatic void advance_phase(input logic [7:0] c);
        case (line_phase)
            PH_LEAD: begin
                if (!is_space(c)) line_phase = (c == CH_G) ? PH_G : PH_FAIL;
            end
            PH_G:   line_phase = (c == CH_P) ? PH_GP : PH_FAIL;
            PH_GP:  line_phase = (c == CH_I) ? PH_GPI : PH_FAIL;
            PH_GPI: line_phase = (c == CH_SPACE) ? PH_PRESIGN : PH_FAIL;
            PH_PRESIGN: begin
                if (is_space(c)) begin
                end else if (c == CH_PLUS) begin
                    line_phase = PH_NEEDDIGIT;
                end else if (is_digit(c)) begin
                    port_acc = int'(c - CH_ZERO);
                    line_phase = PH_DIGITS;
                end else begin
                    line_phase = PH_FAIL;
                end
            end
            PH_NEEDDIGIT: begin
                if (is_digit(c)) begin
                    port_acc = int'(c - CH_ZERO);
                    line_phase = PH_DIGITS;
                end else begin
                    line_phase = PH_FAIL;
                end
            end
            PH_DIGITS: begin
                if (is_digit(c)) begin
                    port_acc = port_acc * 10 + int'(c - CH_ZERO);
                    if (port_acc > int'(PORT_MAX)) port_acc = int'(PORT_MAX);
                end else if (port_acc < 1) begin
                    line_phase = PH_FAIL;
                end else if (c == CH_SPACE) begin
                    line_phase = PH_PRESPACE;
                end else begin
                    take_pin(c);
                end
            end
            PH_PRESPACE: begin
                if (c != CH_SPACE) take_pin(c);
            end
            PH_PINS: take_pin(c);
            PH_TAIL: begin
                if (!is_space(c)) line_phase = PH_FAIL;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit predict_byte(input logic [7:0] c, input logic ns,
                                        output t_pin_event ev);
        bit matched;
        ev = '0;
        if (ns) begin
            clear_line();
            return 1'b0;
        end
        if (c == CH_LF || c == CH_CR) begin
            if (line_len == 0) return 1'b0;
            matched = (line_phase == PH_TAIL || line_phase == PH_DONE_OK)
                      && port_acc == int'(listen_port);
            if (matched) begin
                ev.play = low_pins[0];
                ev.preview = low_pins[1];
            end
            clear_line();
            return ev.play | ev.preview;
        end
        if (line_len >= LINE_LIMIT - 1) return 1'b0;
        line_len++;
        if (line_phase == PH_FAIL || line_phase == PH_DONE_OK) return 1'b0;
        if (c == CH_NUL) begin
            line_phase = (line_phase == PH_TAIL) ? PH_DONE_OK : PH_FAIL;
            return 1'b0;
        end
        advance_phase(c);
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic ns);
        t_pin_event ev;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= c;
        i_new_session <= ns;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_byte(c, ns, ev)) expected_events.push_back(ev);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
        lines_sent++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_listen_port(input logic [OWN_W-1:0] p);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        listen_port = p;
        port_writes++;
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(3))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_pin(input bit want_low);
        if (want_low) return CH_L_UP;
        case ($urandom_range(3))
            0: return CH_H_UP;
            1: return CH_H_LO;
            2: return CH_L_LO;
            default: return CH_L_UP;
        endcase
    endfunction

    task automatic push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endtask

    task automatic build_gpi_line(ref logic [7:0] q[$]);
        int    port;
        int    pins;
        string digits;
        q.delete();
        repeat ($urandom_range(2)) q.push_back(pick_space());
        push_text(q, "GPI ");
        if ($urandom_range(3) == 0) q.push_back(pick_space());
        case ($urandom_range(11))
            0: q.push_back(CH_PLUS);
            1: q.push_back(CH_MINUS);
            default: begin
            end
        endcase
        case ($urandom_range(9))
            0: port = 0;
            1: port = $urandom_range(5, 99999);
            default: port = ($urandom_range(3) != 0) ? int'(listen_port)
                                                     : $urandom_range(1, 7);
        endcase
        digits = $sformatf("%0d", port);
        if ($urandom_range(7) == 0) digits = {"0", digits};
        if ($urandom_range(15) == 0) digits = {digits, "9999999"};
        push_text(q, digits);
        if ($urandom_range(24) == 0) q.push_back(CH_TAB);
        else repeat ($urandom_range(2)) q.push_back(CH_SPACE);
        pins = PIN_COUNT;
        if ($urandom_range(19) == 0) pins = ($urandom_range(1) != 0) ? PIN_COUNT + 1
                                                                     : PIN_COUNT - 1;
        for (int i = 0; i < pins; i++) begin
            if ($urandom_range(29) == 0) q.push_back(8'($urandom_range(255)));
            else q.push_back(pick_pin(i < 2 && $urandom_range(1) != 0));
        end
        repeat ($urandom_range(2)) q.push_back(pick_space());
        if ($urandom_range(9) == 0) begin
            q.push_back(CH_NUL);
            repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(19) == 0) q.push_back(CH_G);
        case ($urandom_range(2))
            0: q.push_back(CH_LF);
            1: q.push_back(CH_CR);
            default: begin
                q.push_back(CH_CR);
                q.push_back(CH_LF);
            end
        endcase
    endtask

    function automatic void note_mismatch(input string what, input t_pin_event exp_ev,
                                          input t_pin_event act_ev);
        event_mismatches++;
        if (event_mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: expected play=%0b preview=%0b, got play=%0b preview=%0b",
                     what, exp_ev.play, exp_ev.preview, act_ev.play, act_ev.preview);
    endfunction

    always @(negedge i_clk) begin
        if (receiver_holdoff > 0) begin
            i_stall <= 1'b1;
            receiver_holdoff = receiver_holdoff - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : event_check
        t_pin_event due;
        t_pin_event got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.play = o_play_pause;
            got.preview = o_preview_toggle;
            if (expected_events.size() == 0) begin
                note_mismatch("unexpected event", '0, got);
            end else begin
                due = expected_events.pop_front();
                if (due.play !== got.play) note_mismatch("play_pause", due, got);
                if (due.preview !== got.preview) note_mismatch("preview_toggle", due, got);
                events_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d events outstanding", expected_events.size());
            $display("gpi_line_event_parser_core verification failed");
            $finish;
        end
    end

    task automatic test_directed_lines();
        send_idle_pct = 28;
        recv_idle_pct = 79;
        send_text("GPI 1 LLHHH\n");
        send_text("GPI 1 LHhhl\r");
        send_text("\n");
        send_text("GPI 1 hLlll\r\n");
        send_text("GPI 1 HHHHH\n");
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_VT, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_text("GPI ");
        send_byte(CH_TAB, 1'b0);
        send_text("+01 LLhhh ");
        send_byte(CH_FF, 1'b0);
        send_text("\n");
        send_text("GPI -1 LLLLL\n");
        send_text("GPI +-1 LLLLL\n");
        send_text("GPI 0 LLLLL\n");
        send_text("GPI 1\tLLLLL\n");
        send_text("GPI 1LLLLL\n");
        send_text("GPI  1   LlLlL\n");
        send_text("GPI 65536 LLLLL\n");
        send_text("GPI 1 LLLL\n");
        send_text("GPI 1 LLLLLL\n");
        send_text("GPI 1 LLHHHx\n");
        send_text("GPI 1 LLLLL");
        send_byte(CH_NUL, 1'b0);
        send_text("xyz\n");
        send_text("GPI 1 LL");
        send_byte(CH_NUL, 1'b0);
        send_text("LLL\n");
        send_byte(CH_NUL, 1'b0);
        send_text("\n");
        send_text("gpi 1 LLLLL\n");
        send_text("GPI 1 LxLLL\n");
        send_text("GPI 1 LL");
        send_byte(8'hFF, 1'b1);
        send_text("HHH\n");
        send_text("GPI 1 L");
        send_byte(8'hA5, 1'b1);
        send_text("GPI 1 LHHHH\n");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("\r");
    endtask

    task automatic test_overlong_lines();
        write_listen_port(3'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (LINE_LIMIT - 12) send_byte(CH_SPACE, 1'b0);
        send_text("GPI 1 LLHHH\r");
        repeat (LINE_LIMIT - 11) send_byte(CH_SPACE, 1'b0);
        send_text("GPI 1 LLHHH\r");
    endtask

    task automatic check_port_setting(input logic [OWN_W-1:0] p);
        write_listen_port(p);
        for (int port = 0; port < 8; port++) send_text($sformatf("GPI %0d LLhhh\n", port));
        send_text("GPI 65535 hLHHH\n");
    endtask

    task automatic test_listen_port_sweep();
        send_idle_pct = 28;
        recv_idle_pct = 79;
        check_port_setting(3'd0);
        check_port_setting(3'd7);
        check_port_setting(3'd3);
    endtask

    task automatic test_output_holdoff();
        write_listen_port(3'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        receiver_holdoff = 150;
        repeat (12) send_text("GPI 1 LLHHH\n");
    endtask

    task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
        logic [7:0] q[$];
        int         start;
        int         cut;
        write_listen_port(3'($urandom_range(1, 4)));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            cut = -1;
            case ($urandom_range(19))
                14, 15, 16: begin
                    build_gpi_line(q);
                    q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
                end
                17, 18: begin
                    q.delete();
                    repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(255)));
                    q.push_back(CH_LF);
                end
                19: begin
                    build_gpi_line(q);
                    cut = $urandom_range(q.size() - 1);
                end
                default: build_gpi_line(q);
            endcase
            for (int i = 0; i < q.size(); i++) begin
                if (i == cut) send_byte(8'($urandom_range(255)), 1'b1);
                send_byte(q[i], 1'b0);
            end
            lines_sent++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        test_listen_port_sweep();
        test_random_traffic(140, 28, 79);
        test_random_traffic(140, 79, 28);
        test_overlong_lines();
        test_output_holdoff();
        test_random_traffic(140, 0, 0);
        wait_drain();

        $display("Sent %0d bytes in %0d lines over %0d own-port settings;",
                 bytes_sent, lines_sent, port_writes);
        $display("checked %0d pin events, %0d mismatches", events_checked,
                 event_mismatches);
        if (event_mismatches == 0 && expected_events.size() == 0) begin
            $display("gpi_line_event_parser_core verification clean");
        end else begin
            $display("gpi_line_event_parser_core verification failed");
        end
        $finish;
    end

endmodule

// ===== gpi_line_event_parser_core.f =====
design/gpi_lep_pkg.sv
design/gpi_line_event_parser_core.sv
dv/tb_top.sv
